// ===== hw/rtl/tfpd_pkg.sv =====
package tfpd_pkg;

  // defaults for the top-level parameters
  localparam int FRAME_BYTES_DEF      = 15;
  localparam int POINTS_PER_FRAME_DEF = 2;

  // frame layout
  localparam int STORE_BYTES    = 12;
  localparam int COUNT_BYTE     = 5;
  localparam int ACK_BYTE       = 6;
  localparam int PT0_BASE       = 0;
  localparam int PT1_BASE       = 7;
  localparam int MAX_POINTS     = 2;

  localparam logic [3:0] POS_IDLE      = 4'hf;
  localparam logic [7:0] ACK_VALUE     = 8'hab;
  localparam logic [6:0] COUNT_MASK    = 7'h7f;
  localparam logic [3:0] EVENT_CONTACT = 4'h6;
  localparam logic [3:0] NIBBLE_MASK   = 4'hf;

  // frame status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ACK   = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PANEL_WIDTH    = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_MAX_POINTS_OUT = 2'd2;

  localparam logic [11:0] PANEL_WIDTH_RST    = 12'd466;
  localparam logic [11:0] PANEL_HEIGHT_RST   = 12'd466;
  localparam logic [1:0]  MAX_POINTS_OUT_RST = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] ev_byte;
    logic [7:0] x_hi;
    logic [7:0] y_hi;
    logic [7:0] xy_lo;
  } point_raw_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [1:0]                  npts;
    point_raw_t [MAX_POINTS-1:0] pts;
  } job_t;

  typedef struct packed {
    logic [11:0] panel_width;
    logic [11:0] panel_height;
    logic [1:0]  max_points_out;
  } panel_cfg_t;

  typedef struct packed {
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic        point_valid;
    logic [1:0]  frame_status;
    logic [1:0]  event_drops;
    logic [1:0]  out_of_range_points;
    logic        contact_active;
    logic        last_of_frame;
  } result_t;

endpackage

// ===== hw/rtl/tfpd_in_if.sv =====
interface tfpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ===== hw/rtl/tfpd_out_if.sv =====
interface tfpd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] touch_x;
  logic [11:0] touch_y;
  logic        point_valid;
  logic [1:0]  frame_status;
  logic [1:0]  event_drops;
  logic [1:0]  out_of_range_points;
  logic        contact_active;
  logic        last_of_frame;

  modport source (output valid, output touch_x, output touch_y, output point_valid,
                  output frame_status, output event_drops,
                  output out_of_range_points, output contact_active,
                  output last_of_frame, input ready);
  modport sink (input valid, input touch_x, input touch_y, input point_valid,
                input frame_status, input event_drops,
                input out_of_range_points, input contact_active,
                input last_of_frame, output ready);
endinterface

// ===== hw/rtl/tfpd_cfg_if.sv =====
interface tfpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [11:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hw/rtl/tfpd_front.sv =====
module tfpd_front #(
  parameter int FRAME_BYTES      = tfpd_pkg::FRAME_BYTES_DEF,
  parameter int POINTS_PER_FRAME = tfpd_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tfpd_in_if.sink        frame_in,
  output tfpd_pkg::job_t job,
  output logic           job_valid,
  input  logic           job_ready
);
  import tfpd_pkg::*;

  localparam logic [3:0] LAST_POS  = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] FRAME_LEN = 4'(FRAME_BYTES);
  localparam logic [3:0] STORE_LEN = 4'(STORE_BYTES);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [3:0] cur_pos;
  logic       take;
  logic       in_frame;
  logic       at_last;
  logic [7:0] store [STORE_BYTES];
  logic [7:0] view  [STORE_BYTES];

  assign frame_in.ready = job_ready;
  assign take     = frame_in.valid && frame_in.ready;
  assign cur_pos  = frame_in.frame_start ? 4'd0 : pos;
  assign in_frame = cur_pos < FRAME_LEN;
  assign at_last  = in_frame && (cur_pos == LAST_POS);
  assign job_valid = take && at_last;

  always_comb begin
    pos_next = pos;
    if (take && in_frame) begin
      pos_next = at_last ? POS_IDLE : cur_pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_frame && (cur_pos < STORE_LEN)) begin
      store[cur_pos] <= frame_in.frame_byte;
    end
  end

  // the final byte may itself be a stored byte on short frames
  always_comb begin
    for (int k = 0; k < STORE_BYTES; k++) begin
      view[k] = (take && cur_pos == 4'(k)) ? frame_in.frame_byte : store[k];
    end
  end

  always_comb begin
    job = '0;
    if (view[ACK_BYTE] != ACK_VALUE) begin
      job.status = STATUS_BAD_ACK;
    end else if ((view[COUNT_BYTE][6:0] & COUNT_MASK) > 7'(POINTS_PER_FRAME)) begin
      job.status = STATUS_TOO_MANY;
    end else begin
      job.status = STATUS_OK;
    end
    job.npts   = view[COUNT_BYTE][1:0];
    job.pts[0] = '{view[PT0_BASE], view[PT0_BASE+1], view[PT0_BASE+2], view[PT0_BASE+3]};
    job.pts[1] = '{view[PT1_BASE], view[PT1_BASE+1], view[PT1_BASE+2], view[PT1_BASE+3]};
  end

endmodule

// ===== hw/rtl/tfpd_queue.sv =====
module tfpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  tfpd_pkg::job_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output tfpd_pkg::job_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import tfpd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/tfpd_back.sv =====
module tfpd_back #(
  parameter int POINTS_PER_FRAME = tfpd_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tfpd_pkg::panel_cfg_t cfg,
  input  tfpd_pkg::job_t       job,
  input  logic                 job_valid,
  output logic                 job_ready,
  tfpd_out_if.source           point_out
);
  import tfpd_pkg::*;

  localparam logic [1:0] PPF = 2'(POINTS_PER_FRAME);

  logic [11:0] px       [MAX_POINTS];
  logic [11:0] py       [MAX_POINTS];
  logic [11:0] mx       [MAX_POINTS];
  logic [11:0] my       [MAX_POINTS];
  logic        ev_ok    [MAX_POINTS];
  logic        in_panel [MAX_POINTS];
  logic [1:0]  limit;
  logic        exam0, exam1, keep0, keep1;
  logic [1:0]  rej, oor;
  result_t     first_r, second_r;
  result_t     out_q, second_q;
  logic        out_valid;
  logic        second_pending;
  logic        slot_free;

  // per-point unpack, range check and mirror
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      px[i]       = {job.pts[i].x_hi, job.pts[i].xy_lo[7:4]};
      py[i]       = {job.pts[i].y_hi, job.pts[i].xy_lo[3:0]};
      ev_ok[i]    = (job.pts[i].ev_byte[3:0] & NIBBLE_MASK) == EVENT_CONTACT;
      in_panel[i] = (px[i] < cfg.panel_width) && (py[i] < cfg.panel_height);
      mx[i]       = cfg.panel_width - 12'd1 - px[i];
      my[i]       = cfg.panel_height - 12'd1 - py[i];
    end
  end

  always_comb begin
    limit = (cfg.max_points_out > PPF) ? PPF : cfg.max_points_out;
    exam0 = (job.npts >= 2'd1) && (limit != 2'd0);
    keep0 = exam0 && ev_ok[0] && in_panel[0];
    exam1 = (job.npts >= 2'd2) && ((keep0 ? 2'd1 : 2'd0) < limit);
    keep1 = exam1 && ev_ok[1] && in_panel[1];
    rej   = 2'(exam0 && !ev_ok[0]) + 2'(exam1 && !ev_ok[1]);
    oor   = 2'(exam0 && ev_ok[0] && !in_panel[0]) + 2'(exam1 && ev_ok[1] && !in_panel[1]);

    first_r  = '0;
    second_r = '0;
    first_r.frame_status  = job.status;
    first_r.last_of_frame = 1'b1;
    if (job.status == STATUS_OK) begin
      first_r.event_drops         = rej;
      first_r.out_of_range_points = oor;
      if (keep0 || keep1) begin
        first_r.point_valid    = 1'b1;
        first_r.contact_active = 1'b1;
        first_r.touch_x        = keep0 ? mx[0] : mx[1];
        first_r.touch_y        = keep0 ? my[0] : my[1];
        first_r.last_of_frame  = !(keep0 && keep1);
      end
    end
    second_r.touch_x             = mx[1];
    second_r.touch_y             = my[1];
    second_r.point_valid         = 1'b1;
    second_r.frame_status        = STATUS_OK;
    second_r.event_drops         = rej;
    second_r.out_of_range_points = oor;
    second_r.contact_active      = 1'b1;
    second_r.last_of_frame       = 1'b1;
  end

  assign slot_free = !out_valid || point_out.ready;
  assign job_ready = slot_free && !second_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (slot_free) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else if (job_valid) begin
        out_valid      <= 1'b1;
        second_pending <= (job.status == STATUS_OK) && keep0 && keep1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (second_pending) begin
        out_q <= second_q;
      end else if (job_valid) begin
        out_q    <= first_r;
        second_q <= second_r;
      end
    end
  end

  assign point_out.valid               = out_valid;
  assign point_out.touch_x             = out_q.touch_x;
  assign point_out.touch_y             = out_q.touch_y;
  assign point_out.point_valid         = out_q.point_valid;
  assign point_out.frame_status        = out_q.frame_status;
  assign point_out.event_drops         = out_q.event_drops;
  assign point_out.out_of_range_points = out_q.out_of_range_points;
  assign point_out.contact_active      = out_q.contact_active;
  assign point_out.last_of_frame       = out_q.last_of_frame;

endmodule

// ===== hw/rtl/touch_frame_point_decoder_top.sv =====
// touch report frame decoder: takes one report byte per cycle on frame_in, a byte with
// frame_start high begins a new frame, and at the last byte of the frame (FRAME_BYTES-1)
// the frame is checked and decoded. the result channel gives one beat per kept point,
// x and y mirrored against the panel size, or a single status beat when nothing is
// kept; the last beat of a frame has last_of_frame set. bytes after the last one are
// dropped until the next frame_start. frame_in takes a byte every cycle while the
// two-entry frame queue has room; the first result beat of a frame passes through the
// frame queue and the output register, and the output stage delivers one beat per cycle
// while point_out is ready, so a frame yields at most two output beats. configuration
// writes are always accepted and should only be made while no frame is in flight.
module touch_frame_point_decoder_top #(
  parameter int FRAME_BYTES      = tfpd_pkg::FRAME_BYTES_DEF,
  parameter int POINTS_PER_FRAME = tfpd_pkg::POINTS_PER_FRAME_DEF
) (
  input logic        clk,
  input logic        rst,
  tfpd_in_if.sink    frame_in,
  tfpd_out_if.source point_out,
  tfpd_cfg_if.sink   cfg
);
  import tfpd_pkg::*;

  panel_cfg_t panel_cfg;
  job_t       front_job;
  logic       front_valid;
  logic       front_ready;
  job_t       back_job;
  logic       back_valid;
  logic       back_ready;

  // configuration registers, always ready for a write
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_cfg.panel_width    <= PANEL_WIDTH_RST;
      panel_cfg.panel_height   <= PANEL_HEIGHT_RST;
      panel_cfg.max_points_out <= MAX_POINTS_OUT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_PANEL_WIDTH:    panel_cfg.panel_width    <= cfg.wr_data;
        REG_PANEL_HEIGHT:   panel_cfg.panel_height   <= cfg.wr_data;
        REG_MAX_POINTS_OUT: panel_cfg.max_points_out <= cfg.wr_data[1:0];
        default: ;
      endcase
    end
  end

  // front: byte position, frame store, frame-level checks
  tfpd_front #(
    .FRAME_BYTES      (FRAME_BYTES),
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (frame_in),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // short queue of decoded frames between front and back
  tfpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // back: point checks, mirroring and result sequencing
  tfpd_back #(
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (panel_cfg),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .point_out (point_out)
  );

endmodule
